FILE: rtl/ghpa_pkg.sv
// ----------------------------------------------------------------------------
// ghpa_pkg: shared types and codes for the handle page allocator
// request and response words, operation codes, controller states and the
// command group passed from the controller to the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ghpa_pkg;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 5;
  localparam int GEN_W  = 32;
  localparam int USED_W = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ACTIVATE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SHUTDOWN = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_INIT     = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   page_id;
    logic [GEN_W-1:0]  page_generation;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   new_id;
    logic [GEN_W-1:0]  new_generation;
    logic [ID_W-1:0]   active_id;
    logic [GEN_W-1:0]  active_generation;
    logic [ID_W-1:0]   pending_id;
    logic [GEN_W-1:0]  pending_generation;
    logic              update_pending;
    logic [USED_W-1:0] used_pages;
    logic              is_initialized;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;  // latch request, read generation store, register free search
    logic execute;  // apply the operation and load the response register
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ghpa_ctrl.sv
// ----------------------------------------------------------------------------
// ghpa_ctrl: request sequencer
// two-state controller: capture a request word, then execute it once the
// response register is free; owns the response valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghpa_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  output ghpa_pkg::cmd_t    cmd
);

  ghpa_pkg::state_t state, state_next;
  logic             rsp_valid_next;
  logic             rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ghpa_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ghpa_pkg::ST_IDLE: begin
        if (req_valid) state_next = ghpa_pkg::ST_EXEC;
      end
      ghpa_pkg::ST_EXEC: begin
        if (rsp_free) state_next = ghpa_pkg::ST_IDLE;
      end
      default: state_next = ghpa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_stall   = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ghpa_pkg::ST_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      ghpa_pkg::ST_EXEC: begin
        cmd.execute = rsp_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == ghpa_pkg::ST_EXEC)
    else $error("accepted request did not move to execute");

  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> rsp_valid && state == ghpa_pkg::ST_IDLE)
    else $error("execute did not present a response");

  a_no_exec_when_blocked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !cmd.execute)
    else $error("execute overwrote a stalled response");
`endif

endmodule

`default_nettype wire

FILE: rtl/ghpa_dp.sv
// ----------------------------------------------------------------------------
// ghpa_dp: page table datapath
// page flags, generation store, handles, counters and the response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghpa_dp #(
  parameter int PAGE_COUNT = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  ghpa_pkg::cmd_t   cmd,
  input  ghpa_pkg::req_t   req,
  output ghpa_pkg::rsp_t   rsp
);

  localparam int IDX_W = $clog2(PAGE_COUNT);
  localparam int CNT_W = $clog2(PAGE_COUNT + 1);

  // page state
  logic [PAGE_COUNT-1:0]          in_use, in_use_next;
  logic [PAGE_COUNT-1:0]          ready, ready_next;
  logic [PAGE_COUNT-1:0]          gen_valid, gen_valid_next;
  logic [ghpa_pkg::GEN_W-1:0]     gen_mem [PAGE_COUNT];
  logic                           mem_we;

  // global state
  logic [ghpa_pkg::GEN_W-1:0]     gen_counter, gen_counter_next;
  logic [ghpa_pkg::ID_W-1:0]      active_id, active_id_next;
  logic [ghpa_pkg::GEN_W-1:0]     active_gen, active_gen_next;
  logic [ghpa_pkg::ID_W-1:0]      pending_id, pending_id_next;
  logic [ghpa_pkg::GEN_W-1:0]     pending_gen, pending_gen_next;
  logic                           update_flag, update_flag_next;
  logic                           init_mark, init_mark_next;
  logic [CNT_W-1:0]               used_cnt, used_cnt_next;

  // captured request
  logic [ghpa_pkg::FUNC_W-1:0]    op_func;
  logic [ghpa_pkg::ID_W-1:0]      op_id;
  logic [ghpa_pkg::GEN_W-1:0]     op_gen;
  logic [IDX_W-1:0]               op_idx;
  logic                           id_ok;
  logic [ghpa_pkg::GEN_W-1:0]     rd_gen;
  logic                           rd_valid;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;

  // request side decode and free search
  logic                           req_id_ok;
  logic [ghpa_pkg::ID_W-1:0]      req_id_m1;
  logic [IDX_W-1:0]               req_idx;
  logic                           srch_found;
  logic [IDX_W-1:0]               srch_idx;

  // execute side
  logic [ghpa_pkg::GEN_W-1:0]     stored_gen;
  logic                           gen_match;
  logic [IDX_W:0]                 free_num;
  ghpa_pkg::rsp_t                 rsp_next;

  assign req_id_ok = (req.page_id != '0) && (int'(req.page_id) <= PAGE_COUNT);
  assign req_id_m1 = req.page_id - ghpa_pkg::ID_W'(1);
  assign req_idx   = req_id_ok ? IDX_W'(req_id_m1) : '0;

  // lowest page not in use
  always_comb begin
    srch_found = 1'b0;
    srch_idx   = '0;
    for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        srch_found = 1'b1;
        srch_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func    <= req.func;
      op_id      <= req.page_id;
      op_gen     <= req.page_generation;
      op_idx     <= req_idx;
      id_ok      <= req_id_ok;
      rd_valid   <= gen_valid[req_idx];
      free_found <= srch_found;
      free_idx   <= srch_idx;
    end
  end

  // generation store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) gen_mem[free_idx] <= gen_counter;
    if (cmd.capture) rd_gen <= gen_mem[req_idx];
  end

  assign stored_gen = rd_valid ? rd_gen : '0;
  assign gen_match  = id_ok && (stored_gen == op_gen);
  assign free_num   = {1'b0, free_idx} + {{IDX_W{1'b0}}, 1'b1};

  always_comb begin
    in_use_next      = in_use;
    ready_next       = ready;
    gen_valid_next   = gen_valid;
    mem_we           = 1'b0;
    gen_counter_next = gen_counter;
    active_id_next   = active_id;
    active_gen_next  = active_gen;
    pending_id_next  = pending_id;
    pending_gen_next = pending_gen;
    update_flag_next = update_flag;
    init_mark_next   = init_mark;
    used_cnt_next    = used_cnt;
    rsp_next         = '0;

    unique case (op_func)
      ghpa_pkg::FUNC_ALLOC: begin
        if (init_mark && free_found) begin
          in_use_next[free_idx]    = 1'b1;
          ready_next[free_idx]     = 1'b0;
          gen_valid_next[free_idx] = 1'b1;
          mem_we                   = cmd.execute;
          gen_counter_next         = gen_counter + ghpa_pkg::GEN_W'(1);
          used_cnt_next            = used_cnt + CNT_W'(1);
          rsp_next.ok              = 1'b1;
          rsp_next.new_id          = ghpa_pkg::ID_W'(free_num);
          rsp_next.new_generation  = gen_counter;
        end
      end
      ghpa_pkg::FUNC_RELEASE: begin
        if (gen_match) begin
          ready_next[op_idx]  = 1'b0;
          in_use_next[op_idx] = 1'b0;
          if (in_use[op_idx]) used_cnt_next = used_cnt - CNT_W'(1);
          rsp_next.ok = 1'b1;
        end
      end
      ghpa_pkg::FUNC_QUERY: begin
        rsp_next.ok = gen_match && ready[op_idx];
      end
      ghpa_pkg::FUNC_ACTIVATE: begin
        if (gen_match && in_use[op_idx]) begin
          ready_next[op_idx] = 1'b1;
          // only a live active handle is parked as pending
          if (active_id != '0) begin
            pending_id_next  = active_id;
            pending_gen_next = active_gen;
          end
          active_id_next   = op_id;
          active_gen_next  = op_gen;
          update_flag_next = 1'b1;
          rsp_next.ok      = 1'b1;
        end
      end
      ghpa_pkg::FUNC_SHUTDOWN: begin
        init_mark_next   = 1'b0;
        in_use_next      = '0;
        ready_next       = '0;
        active_id_next   = '0;
        active_gen_next  = '0;
        pending_id_next  = '0;
        pending_gen_next = '0;
        update_flag_next = 1'b0;
        used_cnt_next    = '0;
        rsp_next.ok      = 1'b1;
      end
      ghpa_pkg::FUNC_INIT: begin
        if (!init_mark) begin
          in_use_next    = '0;
          ready_next     = '0;
          gen_valid_next = '0;
          used_cnt_next  = '0;
          init_mark_next = 1'b1;
        end
        rsp_next.ok = 1'b1;
      end
      default: begin
        rsp_next.ok = 1'b0;
      end
    endcase

    rsp_next.active_id          = active_id_next;
    rsp_next.active_generation  = active_gen_next;
    rsp_next.pending_id         = pending_id_next;
    rsp_next.pending_generation = pending_gen_next;
    rsp_next.update_pending     = update_flag_next;
    rsp_next.used_pages         = ghpa_pkg::USED_W'(used_cnt_next);
    rsp_next.is_initialized     = init_mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use      <= '0;
      ready       <= '0;
      gen_valid   <= '0;
      gen_counter <= ghpa_pkg::GEN_W'(1);
      active_id   <= '0;
      active_gen  <= '0;
      pending_id  <= '0;
      pending_gen <= '0;
      update_flag <= 1'b0;
      init_mark   <= 1'b0;
      used_cnt    <= '0;
    end else if (cmd.execute) begin
      in_use      <= in_use_next;
      ready       <= ready_next;
      gen_valid   <= gen_valid_next;
      gen_counter <= gen_counter_next;
      active_id   <= active_id_next;
      active_gen  <= active_gen_next;
      pending_id  <= pending_id_next;
      pending_gen <= pending_gen_next;
      update_flag <= update_flag_next;
      init_mark   <= init_mark_next;
      used_cnt    <= used_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_used_matches_flags: assert property (@(posedge clk) disable iff (rst)
    int'(used_cnt) == $countones(in_use))
    else $error("used page count out of step with in-use flags");

  a_ready_implies_in_use: assert property (@(posedge clk) disable iff (rst)
    (ready & ~in_use) == '0)
    else $error("page ready while not in use");

  a_idle_pool_empty: assert property (@(posedge clk) disable iff (rst)
    !init_mark |-> in_use == '0)
    else $error("page in use while pool not initialized");
`endif

endmodule

`default_nettype wire

FILE: rtl/generation_handle_page_allocator.sv
// ----------------------------------------------------------------------------
// generation_handle_page_allocator: generational handle page pool
// a request word accepted in idle is executed once the response register is
// free, which loads it and sets response valid; req_stall stays high until then
// the capture step serves the registered read of the page generation store
// reset clears page flags, generation valid bits, handles, update flag and
// initialized mark and sets the generation counter to 1; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module generation_handle_page_allocator #(
  parameter int PAGE_COUNT = 16
) (
  input  wire             clk,
  input  wire             rst,

  // request channel
  input  wire             req_valid,
  output logic            req_stall,
  input  ghpa_pkg::req_t  req,

  // response channel
  output logic            rsp_valid,
  input  wire             rsp_stall,
  output ghpa_pkg::rsp_t  rsp
);

  // controller to datapath commands
  ghpa_pkg::cmd_t cmd;

  // sequencer: idle takes a word, execute waits for a free response register
  ghpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // page table, generation store, handles and response register
  ghpa_dp #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire
